### hdl/midi_tep_pkg.sv
// Shared types and constants for the MIDI track event parser.
package midi_tep_pkg;

	localparam int VarlenMaxBytesDefault = 4;

	localparam logic [31:0] ID_MTRK = 32'h4D54726B;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_TEMPO   = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] ERR_NON_ASCII   = 3'd0;
	localparam logic [2:0] ERR_LONG_VARLEN = 3'd1;
	localparam logic [2:0] ERR_NO_RUNNING  = 3'd2;
	localparam logic [2:0] ERR_META_LEN    = 3'd3;
	localparam logic [2:0] ERR_BAD_STATUS  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED   = 3'd5;

	localparam logic [7:0] META_EOT   = 8'h2F;
	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [7:0] META_SMPTE = 8'h54;
	localparam logic [7:0] META_TSIG  = 8'h58;
	localparam logic [7:0] META_KSIG  = 8'h59;

	typedef enum logic [12:0] {
		PH_ID       = 13'b0000000000001,
		PH_LEN      = 13'b0000000000010,
		PH_SKIP     = 13'b0000000000100,
		PH_DELTA    = 13'b0000000001000,
		PH_STATUS   = 13'b0000000010000,
		PH_DATA1    = 13'b0000000100000,
		PH_DATA2    = 13'b0000001000000,
		PH_SYXLEN   = 13'b0000010000000,
		PH_SYXDATA  = 13'b0000100000000,
		PH_METATYPE = 13'b0001000000000,
		PH_METALEN  = 13'b0010000000000,
		PH_METADATA = 13'b0100000000000,
		PH_ENDPEND  = 13'b1000000000000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] track_index;
		logic [27:0] delta_time;
		logic [7:0]  message_type;
		logic [3:0]  channel;
		logic [23:0] param1;
		logic [7:0]  param2;
		logic [2:0]  error_code;
	} result_t;

endpackage

### hdl/midi_tep_core.sv
// Parser state and per-byte next-state logic; one byte per cycle while step is high.
module midi_tep_core #(
	parameter int VARLEN_MAX_BYTES = midi_tep_pkg::VarlenMaxBytesDefault
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_data,
	output logic                   res_valid,
	output midi_tep_pkg::result_t  res
);

	localparam logic [2:0] VlMax = 3'(VARLEN_MAX_BYTES);

	midi_tep_pkg::phase_t phase_q, phase_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] id_q, id_d, len_q, len_d, pos_q, pos_d, skip_q, skip_d;
	logic [27:0] acc_q, acc_d, dlt_q, dlt_d;
	logic [7:0]  rs_q, rs_d, evs_q, evs_d, mt_q, mt_d, fd_q, fd_d;
	logic [23:0] mb_q, mb_d;
	logic [15:0] trk_q, trk_d;
	logic        halt_q, halt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= midi_tep_pkg::PH_ID;
			cnt_q <= '0; id_q <= '0; len_q <= '0; pos_q <= '0; skip_q <= '0;
			acc_q <= '0; dlt_q <= '0; rs_q <= '0; evs_q <= '0; mt_q <= '0;
			mb_q <= '0; fd_q <= '0; trk_q <= '0; halt_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q <= cnt_d; id_q <= id_d; len_q <= len_d; pos_q <= pos_d;
			skip_q <= skip_d; acc_q <= acc_d; dlt_q <= dlt_d; rs_q <= rs_d;
			evs_q <= evs_d; mt_q <= mt_d; mb_q <= mb_d; fd_q <= fd_d;
			trk_q <= trk_d; halt_q <= halt_d;
		end
	end

	always_comb begin
		logic [27:0] vacc;
		logic [2:0]  vcnt;
		logic        vdone, vlong, evt_done, evt_eot, emit, is_ch, meta_bad;
		logic [3:0]  err;
		logic [7:0]  ctype;
		logic [31:0] skip_m1;
		logic [31:0] idn;
		logic        id_bad, stop;
		midi_tep_pkg::result_t r;

		phase_d = phase_q; cnt_d = cnt_q; id_d = id_q; len_d = len_q; pos_d = pos_q;
		skip_d = skip_q; acc_d = acc_q; dlt_d = dlt_q; rs_d = rs_q; evs_d = evs_q;
		mt_d = mt_q; mb_d = mb_q; fd_d = fd_q; trk_d = trk_q; halt_d = halt_q;
		r = '0;
		r.track_index = trk_q;
		res_valid = 1'b0;
		err = 4'hF;
		evt_done = 1'b0; evt_eot = 1'b0; emit = 1'b0; is_ch = 1'b0;
		ctype = 8'h00; meta_bad = 1'b0;

		vacc = {acc_q[20:0], data_byte[6:0]};
		vcnt = cnt_q + 3'd1;
		vdone = !data_byte[7];
		vlong = data_byte[7] && (vcnt >= VlMax);
		skip_m1 = skip_q - 32'd1;

		// chunk id check: scan from the top byte down to any zero byte
		idn = {id_q[23:0], data_byte};
		id_bad = 1'b0; stop = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (!stop) begin
				if (idn[31-8*i -: 8] == 8'h00) stop = 1'b1;
				else if (idn[31-8*i]) begin
					id_bad = 1'b1; stop = 1'b1;
				end
			end
		end

		if (phase_q == midi_tep_pkg::PH_ENDPEND) begin
			r.kind = midi_tep_pkg::KIND_END;
			res_valid = 1'b1;
			trk_d = trk_q + 16'd1;
			r.track_index = trk_q;
		end
		if ((phase_q == midi_tep_pkg::PH_DELTA || phase_q == midi_tep_pkg::PH_STATUS ||
			phase_q == midi_tep_pkg::PH_DATA1 || phase_q == midi_tep_pkg::PH_DATA2 ||
			phase_q == midi_tep_pkg::PH_SYXLEN || phase_q == midi_tep_pkg::PH_SYXDATA ||
			phase_q == midi_tep_pkg::PH_METATYPE || phase_q == midi_tep_pkg::PH_METALEN ||
			phase_q == midi_tep_pkg::PH_METADATA) && pos_q != '1)
			pos_d = pos_q + 32'd1;

		case (phase_q)
			midi_tep_pkg::PH_ID, midi_tep_pkg::PH_ENDPEND: begin
				phase_d = midi_tep_pkg::PH_ID;
				id_d = idn;
				if (phase_q == midi_tep_pkg::PH_ENDPEND) vcnt = 3'd1;
				cnt_d = vcnt;
				if (vcnt >= 3'd4) begin
					cnt_d = '0;
					if (id_bad) err = {1'b0, midi_tep_pkg::ERR_NON_ASCII};
					len_d = '0;
					phase_d = midi_tep_pkg::PH_LEN;
				end
			end
			midi_tep_pkg::PH_LEN: begin
				len_d = {len_q[23:0], data_byte};
				cnt_d = vcnt;
				if (vcnt >= 3'd4) begin
					cnt_d = '0;
					if (id_q == midi_tep_pkg::ID_MTRK) begin
						pos_d = '0;
						if (len_d == '0) begin
							r.kind = midi_tep_pkg::KIND_END;
							res_valid = 1'b1;
							trk_d = trk_q + 16'd1;
							phase_d = midi_tep_pkg::PH_ID;
						end else begin
							phase_d = midi_tep_pkg::PH_DELTA;
							acc_d = '0;
						end
					end else begin
						skip_d = len_d;
						phase_d = (len_d == '0) ? midi_tep_pkg::PH_ID : midi_tep_pkg::PH_SKIP;
					end
				end
			end
			midi_tep_pkg::PH_SKIP: begin
				skip_d = skip_m1;
				if (skip_m1 == '0) begin
					phase_d = midi_tep_pkg::PH_ID; cnt_d = '0;
				end
			end
			midi_tep_pkg::PH_DELTA, midi_tep_pkg::PH_SYXLEN, midi_tep_pkg::PH_METALEN: begin
				acc_d = vacc; cnt_d = vcnt;
				if (vdone) begin
					if (phase_q == midi_tep_pkg::PH_DELTA) begin
						dlt_d = vacc; phase_d = midi_tep_pkg::PH_STATUS;
					end else begin
						skip_d = {4'h0, vacc};
						if (phase_q == midi_tep_pkg::PH_METALEN) mb_d = '0;
						if (vacc != '0)
							phase_d = (phase_q == midi_tep_pkg::PH_SYXLEN) ?
								midi_tep_pkg::PH_SYXDATA : midi_tep_pkg::PH_METADATA;
						else if (phase_q == midi_tep_pkg::PH_SYXLEN) evt_done = 1'b1;
						else begin
							case (mt_q)
								midi_tep_pkg::META_EOT:   evt_eot = 1'b1;
								midi_tep_pkg::META_TEMPO,
								midi_tep_pkg::META_SMPTE,
								midi_tep_pkg::META_TSIG,
								midi_tep_pkg::META_KSIG:  meta_bad = 1'b1;
								default: ;
							endcase
							evt_done = !meta_bad;
						end
					end
				end else if (vlong) err = {1'b0, midi_tep_pkg::ERR_LONG_VARLEN};
			end
			midi_tep_pkg::PH_STATUS: begin
				if (data_byte[7]) begin
					if (data_byte == 8'hF0 || data_byte == 8'hF7) begin
						rs_d = '0; acc_d = '0; cnt_d = '0; phase_d = midi_tep_pkg::PH_SYXLEN;
					end else if (data_byte == 8'hFF) begin
						rs_d = '0; phase_d = midi_tep_pkg::PH_METATYPE;
					end else if (data_byte >= 8'hF0) begin
						err = {1'b0, midi_tep_pkg::ERR_BAD_STATUS};
					end else begin
						rs_d = data_byte; evs_d = data_byte; phase_d = midi_tep_pkg::PH_DATA1;
					end
				end else if (!rs_q[7]) begin
					err = {1'b0, midi_tep_pkg::ERR_NO_RUNNING};
				end else begin
					evs_d = rs_q; fd_d = data_byte;
					if (rs_q[7:4] == 4'hC || rs_q[7:4] == 4'hD) is_ch = 1'b1;
					else phase_d = midi_tep_pkg::PH_DATA2;
				end
			end
			midi_tep_pkg::PH_DATA1: begin
				fd_d = data_byte;
				if (evs_q[7:4] == 4'hC || evs_q[7:4] == 4'hD) is_ch = 1'b1;
				else phase_d = midi_tep_pkg::PH_DATA2;
			end
			midi_tep_pkg::PH_DATA2: is_ch = 1'b1;
			midi_tep_pkg::PH_SYXDATA: begin
				skip_d = skip_m1;
				if (skip_m1 == '0) evt_done = 1'b1;
			end
			midi_tep_pkg::PH_METATYPE: begin
				mt_d = data_byte; acc_d = '0; cnt_d = '0; phase_d = midi_tep_pkg::PH_METALEN;
			end
			midi_tep_pkg::PH_METADATA: begin
				mb_d = {mb_q[15:0], data_byte};
				skip_d = skip_m1;
				if (skip_m1 == '0) begin
					case (mt_q)
						midi_tep_pkg::META_EOT:   meta_bad = (acc_q != 28'd0);
						midi_tep_pkg::META_TEMPO: meta_bad = (acc_q != 28'd3);
						midi_tep_pkg::META_SMPTE: meta_bad = (acc_q != 28'd5);
						midi_tep_pkg::META_TSIG:  meta_bad = (acc_q != 28'd4);
						midi_tep_pkg::META_KSIG:  meta_bad = (acc_q != 28'd2);
						default:                  meta_bad = 1'b0;
					endcase
					if (!meta_bad) begin
						evt_done = 1'b1;
						evt_eot = (mt_q == midi_tep_pkg::META_EOT);
						if (mt_q == midi_tep_pkg::META_TEMPO) begin
							emit = 1'b1;
							r.kind = midi_tep_pkg::KIND_TEMPO;
							r.delta_time = dlt_q;
							r.message_type = midi_tep_pkg::META_TEMPO;
							r.param1 = mb_d;
						end
					end
				end
			end
			default: begin
				phase_d = midi_tep_pkg::PH_ID; cnt_d = '0;
			end
		endcase

		if (meta_bad) err = {1'b0, midi_tep_pkg::ERR_META_LEN};

		if (is_ch) begin
			ctype = {evs_d[7:4], 4'h0};
			emit = 1'b1;
			evt_done = 1'b1;
			r.kind = midi_tep_pkg::KIND_CHANNEL;
			r.delta_time = dlt_q;
			r.message_type = ctype;
			r.channel = evs_d[3:0];
			if (phase_q == midi_tep_pkg::PH_DATA2) begin
				if (evs_q[7:4] == 4'hE) r.param1 = {10'd0, data_byte[6:0], fd_q[6:0]};
				else begin
					r.param1 = {16'd0, fd_q}; r.param2 = data_byte;
				end
			end else r.param1 = {16'd0, data_byte};
		end

		if (evt_done) begin
			if (evt_eot || pos_d >= len_q) begin
				if (emit) phase_d = midi_tep_pkg::PH_ENDPEND;
				else begin
					r = '0;
					r.kind = midi_tep_pkg::KIND_END;
					r.track_index = trk_q;
					trk_d = trk_q + 16'd1;
					phase_d = midi_tep_pkg::PH_ID;
					cnt_d = '0;
					res_valid = 1'b1;
				end
			end else begin
				phase_d = midi_tep_pkg::PH_DELTA; acc_d = '0; cnt_d = '0;
			end
			if (emit) res_valid = 1'b1;
		end

		if (err == 4'hF && end_of_data &&
			!((phase_d == midi_tep_pkg::PH_ID && cnt_d == '0) ||
			phase_d == midi_tep_pkg::PH_ENDPEND))
			err = {1'b0, midi_tep_pkg::ERR_TRUNCATED};
		if (err != 4'hF) begin
			halt_d = 1'b1;
			r = '0;
			r.kind = midi_tep_pkg::KIND_ERROR;
			// a track end given up on this byte still counts the track
			r.track_index = trk_d;
			r.error_code = err[2:0];
			res_valid = 1'b1;
		end
		if (halt_q) begin
			res_valid = 1'b0;
			phase_d = phase_q; cnt_d = cnt_q; id_d = id_q; len_d = len_q;
			pos_d = pos_q; skip_d = skip_q; acc_d = acc_q; dlt_d = dlt_q; rs_d = rs_q;
			evs_d = evs_q; mt_d = mt_q; mb_d = mb_q; fd_d = fd_q; trk_d = trk_q;
		end
		res = r;
	end

	// a pending track end leaves on the next byte unless the parser has halted
	a_endpend: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == midi_tep_pkg::PH_ENDPEND && !halt_q |-> res_valid)
		else $error("pending track end not emitted");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt cleared without reset");
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |-> !res_valid)
		else $error("result while halted");

endmodule

### hdl/midi_track_event_parser.sv
// Top level: stream wrapper around the MIDI track event parser core.
// Takes one file byte per cycle (tdata byte, end-of-data on tlast), one byte
// per clock sustained while m_tready is high; the input is registered into
// the parser state and the result sits in an output register, so a byte is
// accepted whenever that register is empty or being drained in the same
// cycle. Each byte gives zero or one result transaction: a channel event,
// a tempo event, a track end or an error, told apart by the kind on m_tuser.
// After an error nothing more comes out until arst_n is asserted. The track end
// that follows a channel or tempo event finishing a track comes on the next byte.
module midi_track_event_parser #(
	parameter int VARLEN_MAX_BYTES = midi_tep_pkg::VarlenMaxBytesDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic          s_tlast,   // end_of_data
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [95:0]   m_tdata,   // track_index, delta_time, message_type, channel,
	                                  // param1, param2, error_code (low up)
	output logic [1:0]    m_tuser    // [1:0] kind
);

	logic                  step, res_valid;
	midi_tep_pkg::result_t res, out_q;
	logic                  ovalid_q;

	assign s_tready = !ovalid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	midi_tep_core #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_core (
		.clk, .arst_n, .step,
		.data_byte(s_tdata), .end_of_data(s_tlast),
		.res_valid, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (s_tready) ovalid_q <= step && res_valid;
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) out_q <= res;
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {5'd0, out_q.error_code, out_q.param2, out_q.param1, out_q.channel,
		out_q.message_type, out_q.delta_time, out_q.track_index};

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while result stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> m_tvalid)
		else $error("result not registered");

endmodule
